// ===== rtl/gdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdcc_pkg
// Shared types, constants and the root table of the gc deficit copy counter.
// ----------------------------------------------------------------------------
`default_nettype none

package gdcc_pkg;

  localparam int MAX_READ_LEN    = 65536;
  localparam int READ_COUNT_BITS = 32;
  localparam int FRAC_BITS       = 16;
  localparam int LOG_BITS        = 16;

  localparam int CNT_W     = 17;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 48;
  localparam int DIV_CNT_W = 6;
  localparam int SUM_W     = 48;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [39:0] HALF_Q30 = 40'h00_2000_0000;
  localparam logic [8:0]  CNT_SAT  = 9'd256;

  localparam int CFG_EXP_IDX   = 0;
  localparam int CFG_LIMIT_IDX = 1;
  localparam logic [11:0] EXP_RESET   = 12'd384;
  localparam logic [7:0]  LIMIT_RESET = 8'd255;

  typedef struct packed {
    logic [7:0] base_char;
    logic       end_of_read;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  copy_count;
    logic        has_bases;
    logic [15:0] read_gc_fraction;
    logic [15:0] mean_gc_fraction;
    logic [16:0] read_length;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] gc;
    logic [CNT_W-1:0] acgt;
    logic [CNT_W-1:0] all;
  } snap_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [11:0] exponent;
    logic [7:0]  limit;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_GC_WAIT, S_SUM, S_MEAN_GO, S_MEAN_WAIT, S_DECIDE,
    S_Q_WAIT, S_NORM, S_SQ_MUL, S_SQ_ACC, S_EXP_MUL, S_EXP_CHK,
    S_RT_MUL, S_RT_ACC, S_ROUND, S_FINISH
  } state_t;

  typedef logic [LOG_BITS-1:0][31:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    x = x_in;
    res = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // successive roots 2^(2^-j), j = 1..16, in q1.30
  function automatic root_tab_t calc_roots();
    root_tab_t   tab;
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int j = 0; j < LOG_BITS; j++) begin
      root = isqrt64(root << 30);
      tab[j] = root[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = calc_roots();

endpackage

`default_nettype wire

// ===== rtl/gc_deficit_copy_count_top.sv =====
// ----------------------------------------------------------------------------
// gc_deficit_copy_count_top
// Gc fraction per read, running mean and extra copy count for low-gc reads.
// ----------------------------------------------------------------------------
// channel  ports                       transfer
// input    in_valid/in_ready/in_data   one character, end_of_read on the last
// result   out_valid/out_ready/out_data one item per read
// config   cfg_p*                      apb write at 4*index, pready tied high
//
// a character that does not end a read leaves the input ready for the next one.
// after the last character of a read the input is held off while the read is
// processed: the shared divider runs up to three passes, then, when the power
// is needed, the log and power loops share one 32x32 multiplier.
// a full output register holds the sequencer in its last state and stalls input.
// rst_n is synchronous; it restores the registers to 1.5 and 255.
// ----------------------------------------------------------------------------
`default_nettype none

module gc_deficit_copy_count_top
  import gdcc_pkg::*;
#(
  parameter int READ_CNT_W = READ_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [READ_CNT_W-1:0] READS_MAX = '1;

  cfg_t      cfg;
  snap_t     snap;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  state_t    state_r, state_nxt;
  logic      in_acc;
  logic      has;

  logic [SUM_W-1:0]      sum_r;
  logic [READ_CNT_W-1:0] reads_r;
  logic [15:0]           gcq_r, mean_r;
  logic [47:0]           q_r;
  logic [3:0]            sh_r, k_r, bit_r;
  logic [30:0]           y_r;
  logic [15:0]           frac_r, f_r;
  logic [2:0]            ip_r;
  logic [31:0]           r_r;
  logic [8:0]            cnt_r;
  logic [63:0]           prod_r;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mul_p;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  logic                  out_free;

  logic [SUM_W:0]  sum_add;
  logic [31:0]     sq_t;
  logic [39:0]     v_sh, v_rnd;
  logic [9:0]      c_raw;
  logic [7:0]      copies;

  assign cfg_pready = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign has        = snap.acgt != '0;
  assign out_free   = !out_valid_r || out_ready;

  gdcc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  gdcc_base_cnt u_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .item   (in_data),
    .snap   (snap)
  );

  gdcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // shared multiplier operands
  always_comb begin
    case (state_r)
      S_SQ_MUL: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, y_r};
      end
      S_EXP_MUL: begin
        mul_a = {12'd0, k_r, frac_r};
        mul_b = {20'd0, cfg.exponent};
      end
      default: begin
        mul_a = r_r;
        mul_b = ROOTS[bit_r];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    sum_add = {1'b0, sum_r} + {{(SUM_W-15){1'b0}}, gcq_r};
    sq_t    = prod_r[61:30];
    v_sh    = {8'd0, r_r} << ip_r;
    v_rnd   = v_sh + HALF_Q30;
    c_raw   = v_rnd[39:30];
    if (cnt_r > 9'd1) begin
      copies = (cnt_r < {1'b0, cfg.limit}) ? cnt_r[7:0] : cfg.limit;
    end else begin
      copies = 8'd0;
    end
  end

  // sequencer: next state and divider requests
  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.end_of_read) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (has) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(snap.gc) << FRAC_BITS;
          div_req.den   = DIV_DEN_W'(snap.acgt);
          state_nxt     = S_GC_WAIT;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_GC_WAIT: begin
        if (div_rsp.done) state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(sum_r);
        div_req.den   = DIV_DEN_W'(reads_r) + 1'b1;
        state_nxt     = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (div_rsp.done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (has && gcq_r < mean_r && gcq_r != '0) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(mean_r) << 32;
          div_req.den   = DIV_DEN_W'(gcq_r);
          state_nxt     = S_Q_WAIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_Q_WAIT: begin
        if (div_rsp.done) state_nxt = S_NORM;
      end
      S_NORM: begin
        if (q_r[47]) state_nxt = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        state_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        state_nxt = (bit_r == '0) ? S_EXP_MUL : S_SQ_MUL;
      end
      S_EXP_MUL: begin
        state_nxt = S_EXP_CHK;
      end
      S_EXP_CHK: begin
        state_nxt = (prod_r[31:24] >= 8'd8) ? S_FINISH : S_RT_MUL;
      end
      S_RT_MUL: begin
        if (f_r[4'd15 - bit_r]) begin
          state_nxt = S_RT_ACC;
        end else if (bit_r == 4'd15) begin
          state_nxt = S_ROUND;
        end
      end
      S_RT_ACC: begin
        state_nxt = (bit_r == 4'd15) ? S_ROUND : S_RT_MUL;
      end
      S_ROUND: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      reads_r <= '0;
    end else begin
      if (state_r == S_SUM) begin
        sum_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end
      if (state_r == S_FINISH && out_free && reads_r != READS_MAX) begin
        reads_r <= reads_r + 1'b1;
      end
    end
  end

  // datapath of the divider results, the log and power loops and the copy count
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      S_PREP: begin
        gcq_r <= '0;
        cnt_r <= '0;
      end
      S_GC_WAIT: begin
        if (div_rsp.done) begin
          gcq_r <= (div_rsp.quo > 64'hffff) ? 16'hffff : div_rsp.quo[15:0];
        end
      end
      S_MEAN_WAIT: begin
        if (div_rsp.done) begin
          mean_r <= (div_rsp.quo > 64'hffff) ? 16'hffff : div_rsp.quo[15:0];
        end
      end
      S_DECIDE: begin
        // zero gc below a nonzero mean saturates the count
        cnt_r <= (has && gcq_r < mean_r && gcq_r == '0) ? CNT_SAT : 9'd0;
      end
      S_Q_WAIT: begin
        q_r  <= div_rsp.quo[47:0];
        sh_r <= '0;
      end
      S_NORM: begin
        if (q_r[47]) begin
          y_r    <= q_r[47:17];
          k_r    <= 4'd15 - sh_r;
          bit_r  <= 4'd15;
          frac_r <= '0;
        end else begin
          q_r  <= {q_r[46:0], 1'b0};
          sh_r <= sh_r + 1'b1;
        end
      end
      S_SQ_ACC: begin
        if (sq_t[31]) begin
          y_r           <= sq_t[31:1];
          frac_r[bit_r] <= 1'b1;
        end else begin
          y_r <= sq_t[30:0];
        end
        bit_r <= bit_r - 1'b1;
      end
      S_EXP_CHK: begin
        if (prod_r[31:24] >= 8'd8) begin
          cnt_r <= CNT_SAT;
        end
        ip_r  <= prod_r[26:24];
        f_r   <= prod_r[23:8];
        r_r   <= ONE_Q30;
        bit_r <= '0;
      end
      S_RT_MUL: begin
        if (!f_r[4'd15 - bit_r] && bit_r != 4'd15) begin
          bit_r <= bit_r + 1'b1;
        end
      end
      S_RT_ACC: begin
        r_r <= prod_r[61:30];
        if (bit_r != 4'd15) bit_r <= bit_r + 1'b1;
      end
      S_ROUND: begin
        cnt_r <= (c_raw > 10'd256) ? CNT_SAT : c_raw[8:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free) begin
      out_data_r.copy_count       <= copies;
      out_data_r.has_bases        <= has;
      out_data_r.read_gc_fraction <= gcq_r;
      out_data_r.mean_gc_fraction <= mean_r;
      out_data_r.read_length      <= snap.all;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/gdcc_cfg.sv =====
// ----------------------------------------------------------------------------
// gdcc_cfg
// Register file behind the apb-style port: exponent and copy limit.
// ----------------------------------------------------------------------------
`default_nettype none

module gdcc_cfg
  import gdcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  logic [11:0] exp_r;
  logic [7:0]  limit_r;
  logic        wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= EXP_RESET;
      limit_r <= LIMIT_RESET;
    end else if (wr_en) begin
      if (32'(paddr[2]) == CFG_EXP_IDX) begin
        exp_r <= pwdata[11:0];
      end else begin
        limit_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (32'(paddr[2]) == CFG_EXP_IDX) begin
      prdata = {20'd0, exp_r};
    end else begin
      prdata = {24'd0, limit_r};
    end
  end

  assign cfg.exponent = exp_r;
  assign cfg.limit    = limit_r;

endmodule

`default_nettype wire

// ===== rtl/gdcc_base_cnt.sv =====
// ----------------------------------------------------------------------------
// gdcc_base_cnt
// Per-read character, acgt and gc counters; snapshot taken at end of read.
// ----------------------------------------------------------------------------
`default_nettype none

module gdcc_base_cnt
  import gdcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic accept,
  input  in_item_t  item,
  output snap_t     snap
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READ_LEN);

  logic [CNT_W-1:0] gc_r, acgt_r, all_r;
  logic [CNT_W-1:0] gc_nxt, acgt_nxt, all_nxt;
  snap_t            snap_r;
  logic [7:0]       ch_up;
  logic             is_at, is_gc;

  always_comb begin
    ch_up = item.base_char;
    if (item.base_char inside {[8'h61:8'h7a]}) begin
      ch_up = item.base_char - CASE_OFS;
    end
    is_at = (ch_up == CH_A) || (ch_up == CH_T);
    is_gc = (ch_up == CH_G) || (ch_up == CH_C);
    all_nxt  = (all_r < CNT_MAX) ? all_r + 1'b1 : all_r;
    acgt_nxt = ((is_at || is_gc) && acgt_r < CNT_MAX) ? acgt_r + 1'b1 : acgt_r;
    gc_nxt   = (is_gc && gc_r < CNT_MAX) ? gc_r + 1'b1 : gc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r   <= '0;
      acgt_r <= '0;
      all_r  <= '0;
    end else if (accept) begin
      if (item.end_of_read) begin
        gc_r   <= '0;
        acgt_r <= '0;
        all_r  <= '0;
      end else begin
        gc_r   <= gc_nxt;
        acgt_r <= acgt_nxt;
        all_r  <= all_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.end_of_read) begin
      snap_r.gc   <= gc_nxt;
      snap_r.acgt <= acgt_nxt;
      snap_r.all  <= all_nxt;
    end
  end

  assign snap = snap_r;

endmodule

`default_nettype wire

// ===== rtl/gdcc_div.sv =====
// ----------------------------------------------------------------------------
// gdcc_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdcc_div
  import gdcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      cnt_r <= '1;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams reads of characters into the gc deficit copy counter, predicts the
// per-read gc fraction, running mean and extra copy count, and checks every
// result transfer against the prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gdcc_pkg::*;

  localparam int CFG_EXP_ADDR   = 4 * CFG_EXP_IDX;
  localparam int CFG_LIMIT_ADDR = 4 * CFG_LIMIT_IDX;

  // expected read summaries, oldest first
  class read_summary_board;
    out_item_t   pending[$];
    int          mismatches;
    int          reads_checked;
    logic [11:0] exponent;
    logic [7:0]  limit;
    logic [16:0] gc_cnt, acgt_cnt, char_cnt;
    logic [47:0] gc_sum;
    logic [31:0] reads_done;

    function void clear_all();
      pending.delete();
      mismatches = 0;
      reads_checked = 0;
      exponent = EXP_RESET;
      limit = LIMIT_RESET;
      gc_cnt = 0;
      acgt_cnt = 0;
      char_cnt = 0;
      gc_sum = 0;
      reads_done = 0;
    endfunction

    function logic [16:0] sat_inc(logic [16:0] v);
      return (v < MAX_READ_LEN) ? v + 17'd1 : v;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // round((num/den)^(exponent/256)), capped at 256
    function int unsigned deficit_power(logic [63:0] num, logic [63:0] den);
      logic [63:0] q, y, frac, lg, p, ip, f, root, r, v, c;
      int top;
      q = (num << 32) / den;
      top = 63;
      while (top > 0 && q[top] == 1'b0) top--;
      y = q >> (top - 30);
      frac = 0;
      for (int i = LOG_BITS - 1; i >= 0; i--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          frac[i] = 1'b1;
        end
      end
      lg = (64'(top - 32) << LOG_BITS) | frac;
      p = (lg * 64'(exponent)) >> 8;
      ip = p >> LOG_BITS;
      if (ip >= 8) return 256;
      f = p & 64'hFFFF;
      root = 64'd1 << 31;
      r = 64'd1 << 30;
      for (int j = 1; j <= LOG_BITS; j++) begin
        root = int_sqrt(root << 30);
        if (f[LOG_BITS - j]) r = (r * root) >> 30;
      end
      v = r << ip;
      c = (v + (64'd1 << 29)) >> 30;
      return (c > 256) ? 256 : int'(c);
    endfunction

    function void note_char(in_item_t it);
      logic [7:0] ch;
      out_item_t exp_item;
      logic [63:0] gcq, mean, s;
      int unsigned c, copies;
      ch = it.base_char;
      if (ch >= "a" && ch <= "z") ch = ch - CASE_OFS;
      char_cnt = sat_inc(char_cnt);
      if (ch == CH_A || ch == CH_T) begin
        acgt_cnt = sat_inc(acgt_cnt);
      end else if (ch == CH_G || ch == CH_C) begin
        acgt_cnt = sat_inc(acgt_cnt);
        gc_cnt = sat_inc(gc_cnt);
      end
      if (!it.end_of_read) return;
      gcq = 0;
      if (acgt_cnt != 0) begin
        gcq = (64'(gc_cnt) << FRAC_BITS) / acgt_cnt;
        if (gcq > 64'hFFFF) gcq = 64'hFFFF;
        s = 64'(gc_sum) + gcq;
        gc_sum = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
      end
      mean = 64'(gc_sum) / (64'(reads_done) + 1);
      if (mean > 64'hFFFF) mean = 64'hFFFF;
      copies = 0;
      if (acgt_cnt != 0 && gcq < mean) begin
        c = (gcq == 0) ? 256 : deficit_power(mean, gcq);
        if (c > 1) copies = (c < limit) ? c : limit;
      end
      exp_item.copy_count = copies[7:0];
      exp_item.has_bases = (acgt_cnt != 0);
      exp_item.read_gc_fraction = gcq[15:0];
      exp_item.mean_gc_fraction = mean[15:0];
      exp_item.read_length = char_cnt;
      pending.push_back(exp_item);
      if (reads_done != 32'hFFFF_FFFF) reads_done++;
      gc_cnt = 0;
      acgt_cnt = 0;
      char_cnt = 0;
    endfunction

    function void check_summary(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", got);
        return;
      end
      want = pending.pop_front();
      reads_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch read %0d: expected %p, got %p", reads_checked, want, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  in_item_t in_data;
  logic out_valid, out_ready;
  out_item_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  read_summary_board board;
  bit calm_mode;
  bit hold_results;
  int chars_sent;

  gc_deficit_copy_count_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stall (none in calm mode, full during a hold), checked on the accepting edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_summary(out_data);
    if (!rst_n || hold_results) out_ready <= 1'b0;
    else out_ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 33);
  end

  task automatic reg_write(input int addr, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr[2:0];
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == CFG_EXP_ADDR) board.exponent = val[11:0];
    else board.limit = val[7:0];
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    while (!calm_mode && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{base_char: ch, end_of_read: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_char('{base_char: ch, end_of_read: last});
    chars_sent++;
  endtask

  function automatic logic [7:0] pick_char(int gc_bias);
    logic [7:0] ch;
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'($urandom_range(255));
    if ($urandom_range(99) < gc_bias) ch = $urandom_range(1) ? CH_G : CH_C;
    else ch = $urandom_range(1) ? CH_A : CH_T;
    if ($urandom_range(1)) ch = ch + CASE_OFS;
    return ch;
  endfunction

  task automatic send_read(input int len, input int gc_bias);
    for (int i = 0; i < len; i++) send_char(pick_char(gc_bias), i == len - 1);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  initial begin
    int phase_exp[4];
    int phase_lim[4];
    board = new();
    board.clear_all();
    calm_mode = 0;
    hold_results = 0;
    chars_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each base in both cases, a symbol-only read, all-gc and zero-gc
    send_char("A", 1'b0); send_char("c", 1'b0); send_char("G", 1'b0);
    send_char("t", 1'b1);
    send_char("N", 1'b0); send_char(8'hFF, 1'b0); send_char(8'h00, 1'b1);
    send_char("g", 1'b0); send_char("C", 1'b1);
    send_char("a", 1'b0); send_char("T", 1'b0); send_char("A", 1'b1);
    send_char("a", 1'b0); send_char("a", 1'b0); send_char("a", 1'b0);
    send_char("g", 1'b1);
    send_char("Z", 1'b1);
    send_char("C", 1'b0); send_char(8'h7F, 1'b0); send_char("a", 1'b1);
    drain();

    phase_exp = '{256, 4095, 1000, 384};
    phase_lim = '{1, 255, 3, 200};
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(CFG_EXP_ADDR, phase_exp[ph]);
      reg_write(CFG_LIMIT_ADDR, phase_lim[ph]);
      calm_mode = (ph == 2);
      if (ph == 1) begin
        // long receiver hold-off so the block backs up its input
        hold_results = 1;
        fork
          begin
            repeat (3000) @(posedge clk);
            hold_results = 0;
          end
        join_none
      end
      while (chars_sent < 100 * (ph + 1) + 20)
        send_read($urandom_range(1, 12), $urandom_range(100));
      drain();
    end

    // long read to exercise counter width
    send_read(300, 50);
    drain();

    $display("covered %0d characters, %0d reads across five register settings",
             chars_sent, board.reads_checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/gdcc_pkg.sv
rtl/gdcc_cfg.sv
rtl/gdcc_base_cnt.sv
rtl/gdcc_div.sv
rtl/gc_deficit_copy_count_top.sv
tb/tb_top.sv
